### hdl/sqdo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqdo_pkg: shared types and constants for the square/diagonal overlay
// Pixel and result transfer types, register indexes, paint kinds and
// geometry widths.
// ----------------------------------------------------------------------------
package sqdo_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int COORD_W = 12;
   localparam int CHAN_W  = 8;
   localparam int CORNER_W = 14;
   localparam int SIDE_W  = 13;
   localparam int THICK_W = 10;
   localparam int COLOR_W = 24;
   localparam int KIND_W  = 2;

   // signed width that holds every intermediate of the geometry tests
   localparam int GEO_W = 18;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_CORNER_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CORNER_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THICKNESS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_ENABLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_COLOR  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_COLOR  = 3'd6;

   localparam logic [KIND_W-1:0] KIND_KEEP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FILL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LINE = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [CHAN_W-1:0]  in_red;
      logic [CHAN_W-1:0]  in_green;
      logic [CHAN_W-1:0]  in_blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [KIND_W-1:0] paint_kind;
   } rsp_type;

endpackage

### hdl/square_diagonal_overlay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_diagonal_overlay: per-pixel square outline and diagonal overlay
// Paints each pixel of a stream with the line colour, the fill colour or
// leaves it unchanged, depending on where it falls relative to a square.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one pixel per transfer (column, row, colour), valid/stall.
//   rsp_*  : one result per pixel (colour and paint kind), valid/stall.
//   csr_*  : register writes, index 0..6 in the order corner_x, corner_y,
//            side_length, thickness, fill_enable, fill_color, line_color;
//            other indexes are dropped. csr_ready is always high.
//   A pixel taken from req is held in the input register; the geometry
//   tests feed the result register, which drives rsp_valid and rsp_payload,
//   so every result passes through both registers in that order.
//   Throughput is one pixel per cycle, set by the two-register pipeline
//   with no shared unit; a new pixel enters every cycle rsp is not stalled.
//   When the receiver stalls, the result register holds, the input register
//   holds its pixel, and req_stall rises once both are full.
//   Synchronous reset empties both pipeline registers and clears all
//   configuration registers to 0. Write configuration only while idle.
// ----------------------------------------------------------------------------
module square_diagonal_overlay
   import sqdo_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CORNER_W-1:0] corner_x_ff;
   logic [CORNER_W-1:0] corner_y_ff;
   logic [SIDE_W-1:0]   side_length_ff;
   logic [THICK_W-1:0]  thickness_ff;
   logic                fill_enable_ff;
   logic [COLOR_W-1:0]  fill_color_ff;
   logic [COLOR_W-1:0]  line_color_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_x_ff    <= '0;
         corner_y_ff    <= '0;
         side_length_ff <= '0;
         thickness_ff   <= '0;
         fill_enable_ff <= 1'b0;
         fill_color_ff  <= '0;
         line_color_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CORNER_X:    corner_x_ff    <= csr_data[CORNER_W-1:0];
            CSR_CORNER_Y:    corner_y_ff    <= csr_data[CORNER_W-1:0];
            CSR_SIDE_LENGTH: side_length_ff <= csr_data[SIDE_W-1:0];
            CSR_THICKNESS:   thickness_ff   <= csr_data[THICK_W-1:0];
            CSR_FILL_ENABLE: fill_enable_ff <= csr_data[0];
            CSR_FILL_COLOR:  fill_color_ff  <= csr_data[COLOR_W-1:0];
            CSR_LINE_COLOR:  line_color_ff  <= csr_data[COLOR_W-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: input register (stage 1), result register (stage 2)
   // ------------------------------------------------------------------
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_pix_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type out_rsp_in;
   logic    advance_out;
   logic    req_take;

   // the result register may load when empty or when its result leaves now
   assign advance_out = !out_valid_ff || !rsp_stall;
   // stall the sender only when the input register is full and cannot move
   assign req_stall   = in_valid_ff && !advance_out;
   assign req_take    = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance_out ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance_out ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pix_ff <= req_payload;
      end
      if (advance_out) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   // ------------------------------------------------------------------
   // Geometry, all in one signed width wide enough for every sum
   // ------------------------------------------------------------------
   localparam logic signed [GEO_W-1:0] ONE  = GEO_W'(1);
   localparam logic signed [GEO_W-1:0] ZERO = '0;

   logic signed [GEO_W-1:0] px_s;
   logic signed [GEO_W-1:0] py_s;
   logic signed [GEO_W-1:0] cx_s;
   logic signed [GEO_W-1:0] cy_s;
   logic signed [GEO_W-1:0] s_s;
   logic signed [GEO_W-1:0] t_s;
   logic signed [GEO_W-1:0] neg_t;
   logic signed [GEO_W-1:0] dx;
   logic signed [GEO_W-1:0] dy;
   logic signed [GEO_W-1:0] d1;
   logic signed [GEO_W-1:0] d2;
   logic signed [GEO_W-1:0] s_m1_dy;   // s - 1 - dy
   logic signed [GEO_W-1:0] s_m1_dx;   // s - 1 - dx
   logic signed [GEO_W-1:0] s_t_m1;    // s + t - 1
   logic signed [GEO_W-1:0] s_m_dx;    // s - dx

   assign px_s  = $signed({{(GEO_W-COORD_W){1'b0}}, in_pix_ff.pixel_x});
   assign py_s  = $signed({{(GEO_W-COORD_W){1'b0}}, in_pix_ff.pixel_y});
   assign cx_s  = $signed({{(GEO_W-CORNER_W){corner_x_ff[CORNER_W-1]}}, corner_x_ff});
   assign cy_s  = $signed({{(GEO_W-CORNER_W){corner_y_ff[CORNER_W-1]}}, corner_y_ff});
   assign s_s   = $signed({{(GEO_W-SIDE_W){1'b0}}, side_length_ff});
   assign t_s   = $signed({{(GEO_W-THICK_W){1'b0}}, thickness_ff});
   assign neg_t = ZERO - t_s;

   assign dx      = px_s - cx_s;
   assign dy      = cy_s - py_s;
   assign s_m1_dy = s_s - ONE - dy;
   assign s_m1_dx = s_s - ONE - dx;
   assign s_t_m1  = s_s + t_s - ONE;
   assign s_m_dx  = s_s - dx;
   assign d1      = dx - dy;
   assign d2      = dx - s_m1_dy;

   logic in_image;
   logic on_diag;
   logic on_top;
   logic on_bottom;
   logic on_left;
   logic on_right;
   logic on_line;
   logic in_square;

   assign in_image = (32'(in_pix_ff.pixel_x) < 32'(MAX_DIM))
                  && (32'(in_pix_ff.pixel_y) < 32'(MAX_DIM));

   // diagonals: rows 0..s, closer than t to either diagonal
   assign on_diag = (dy >= ZERO) && (dy <= s_s)
                 && (((d1 > neg_t) && (d1 < t_s)) || ((d2 > neg_t) && (d2 < t_s)));
   // border band, t pixels outside each edge, mitred at the corners
   assign on_top    = (dy >= neg_t) && (dy <= -ONE) && (dx >= dy) && (dx <= s_m1_dy);
   assign on_bottom = (dy >= s_s) && (dy <= s_t_m1) && (dx >= s_m1_dy) && (dx <= dy);
   assign on_left   = (dx >= neg_t) && (dx <= -ONE) && (dy >= dx + ONE) && (dy <= s_m1_dx);
   assign on_right  = (dx >= s_s) && (dx <= s_t_m1) && (dy >= s_m_dx) && (dy <= dx);

   // zero thickness draws no lines at all
   assign on_line   = (thickness_ff != '0)
                   && (on_diag || on_top || on_bottom || on_left || on_right);
   assign in_square = (dx >= ZERO) && (dx < s_s) && (dy >= ZERO) && (dy < s_s);

   // line colour wins over fill; pixels outside the image keep their colour
   always_comb begin
      out_rsp_in.out_red    = in_pix_ff.in_red;
      out_rsp_in.out_green  = in_pix_ff.in_green;
      out_rsp_in.out_blue   = in_pix_ff.in_blue;
      out_rsp_in.paint_kind = KIND_KEEP;
      if (in_image && on_line) begin
         out_rsp_in.out_red    = line_color_ff[23:16];
         out_rsp_in.out_green  = line_color_ff[15:8];
         out_rsp_in.out_blue   = line_color_ff[7:0];
         out_rsp_in.paint_kind = KIND_LINE;
      end else if (in_image && fill_enable_ff && in_square) begin
         out_rsp_in.out_red    = fill_color_ff[23:16];
         out_rsp_in.out_green  = fill_color_ff[15:8];
         out_rsp_in.out_blue   = fill_color_ff[7:0];
         out_rsp_in.paint_kind = KIND_FILL;
      end
   end

`ifndef SYNTHESIS
   // an accepted pixel always lands in the input register
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted pixel did not reach the input register");

   // stalling the sender means both registers are full and the output is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("req_stall raised with room in the pipeline");

   // a pending pixel moves on to the result register when the output is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_stall) |=> rsp_valid)
      else $error("pending pixel did not advance to the result register");

   // only the three defined paint kinds leave the block
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.paint_kind == KIND_KEEP) ||
                     (rsp_payload.paint_kind == KIND_FILL) ||
                     (rsp_payload.paint_kind == KIND_LINE)))
      else $error("invalid paint kind on result");
`endif

endmodule
